// ===== sv/frtg_pkg.sv =====
// Shared types, constants and codes for the frame rate tier governor.
package frtg_pkg;

	// Default parameter values
	localparam int DEF_COUNT_WIDTH = 16;
	localparam int DEF_TIME_WIDTH  = 32;

	// Field widths
	localparam int CFG_WIDTH        = 24;
	localparam int CFG_INDEX_WIDTH  = 3;
	localparam int FRAME_WIDTH      = 24;
	localparam int FRAC_BITS        = 8;
	localparam int SMOOTH_WIDTH     = FRAME_WIDTH + FRAC_BITS;
	localparam int RATE_WIDTH       = 16;
	localparam int TIER_WIDTH       = 2;
	localparam int FACTOR_WIDTH     = 3;
	localparam int MUL_WIDTH        = 32;
	localparam int RATE_SCALE_WIDTH = 24;

	// Divide by ten: x / 10 == (x * RECIP_TEN) >> RECIP_SHIFT for any 32-bit x
	localparam logic [MUL_WIDTH-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
	localparam int                   RECIP_SHIFT = 35;

	// Frames per second in 1/16 units: count * 16 * 1e6 / elapsed microseconds
	localparam logic [RATE_SCALE_WIDTH-1:0] RATE_SCALE = 24'd16_000_000;
	localparam logic [RATE_WIDTH-1:0]       RATE_SEED  = 16'd960;
	localparam logic [FRAME_WIDTH-1:0]      FRAME_MAX  = 24'hFF_FFFF;

	// Configuration reset values
	localparam logic [CFG_WIDTH-1:0] LOW_POWER_THR_RST = 24'd33330;
	localparam logic [CFG_WIDTH-1:0] BALANCED_THR_RST  = 24'd18000;
	localparam logic [CFG_WIDTH-1:0] HIGH_THR_RST      = 24'd16000;
	localparam logic [CFG_WIDTH-1:0] FRAME_BUDGET_RST  = 24'd16670;
	localparam logic [CFG_WIDTH-1:0] WINDOW_RST        = 24'd500000;

	// Tier codes
	localparam logic [TIER_WIDTH-1:0] TIER_HIGH     = 2'd0;
	localparam logic [TIER_WIDTH-1:0] TIER_BALANCED = 2'd1;
	localparam logic [TIER_WIDTH-1:0] TIER_LOW      = 2'd2;
	localparam logic [TIER_WIDTH-1:0] TIER_UNUSED   = 2'd3;

	// Physics and collision factors in quarters
	localparam logic [FACTOR_WIDTH-1:0] FACTOR_NONE    = 3'd0;
	localparam logic [FACTOR_WIDTH-1:0] FACTOR_QUARTER = 3'd1;
	localparam logic [FACTOR_WIDTH-1:0] FACTOR_HALF    = 3'd2;
	localparam logic [FACTOR_WIDTH-1:0] FACTOR_FULL    = 3'd4;

	typedef enum logic [1:0] {
		OP_END_FRAME    = 2'd0,
		OP_SET_TIER     = 2'd1,
		OP_SET_PLATFORM = 2'd2,
		OP_CLEAR_LOCK   = 2'd3
	} opcode_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_LOW_POWER_THR = 3'd0,
		CFG_BALANCED_THR  = 3'd1,
		CFG_HIGH_THR      = 3'd2,
		CFG_FRAME_BUDGET  = 3'd3,
		CFG_WINDOW        = 3'd4
	} cfg_index_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SPAN,
		S_DIFF,
		S_SCALE,
		S_SMOOTH,
		S_RATE_MUL,
		S_DIV,
		S_SAMPLE,
		S_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_item;
		logic span;
		logic diff;
		logic scale;
		logic smooth;
		logic rate_mul;
		logic div_step;
		logic sample;
		logic tier;
		logic load_result;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_frame;
		logic started;
		logic window_due;
		logic div_last;
	} status_t;

endpackage

// ===== sv/frtg_ctrl.sv =====
// Controller state machine of the frame rate tier governor.
module frtg_ctrl import frtg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	output logic    result_valid,
	input  logic    result_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   result_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Result valid: set on load, drop once the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_SPAN;
				end
			end
			S_SPAN: begin
				if (status.is_frame) begin
					cmd.span = 1'b1;
					state_d  = S_DIFF;
				end else begin
					cmd.tier = 1'b1;
					state_d  = S_DONE;
				end
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = S_SCALE;
			end
			S_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = S_SMOOTH;
			end
			S_SMOOTH: begin
				cmd.smooth = 1'b1;
				if (status.started && status.window_due) begin
					state_d = S_RATE_MUL;
				end else begin
					state_d = S_DONE;
				end
			end
			S_RATE_MUL: begin
				cmd.rate_mul = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = S_SAMPLE;
				end
			end
			S_SAMPLE: begin
				cmd.sample = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (!result_valid_q || !result_stall) begin
					cmd.load_result = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/frtg_dpath.sv =====
// Datapath of the frame rate tier governor: state, smoothing, rate divider, result register.
module frtg_dpath import frtg_pkg::*; #(
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
	parameter int TIME_WIDTH  = DEF_TIME_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_WIDTH-1:0]       cfg_data,
	input  logic [1:0]                 opcode,
	input  logic [TIME_WIDTH-1:0]      start_time_us,
	input  logic [TIME_WIDTH-1:0]      end_time_us,
	input  logic [TIER_WIDTH-1:0]      tier_value,
	input  cmd_t                       cmd,
	output status_t                    status,
	output logic [TIER_WIDTH-1:0]      active_tier,
	output logic [TIER_WIDTH-1:0]      suggested_tier,
	output logic                       platform_locked,
	output logic [FRAME_WIDTH-1:0]     last_frame_us,
	output logic [SMOOTH_WIDTH-1:0]    smoothed_frame_q8,
	output logic [RATE_WIDTH-1:0]      fps_x16,
	output logic                       budget_exceeded,
	output logic [FACTOR_WIDTH-1:0]    physics_factor_q,
	output logic [FACTOR_WIDTH-1:0]    collision_factor_q
);

	localparam int DVD_WIDTH   = COUNT_WIDTH + RATE_SCALE_WIDTH;
	localparam int CNT_WIDTH   = $clog2(DVD_WIDTH + 1);
	localparam int RECIP_WIDTH = 2 * MUL_WIDTH - RECIP_SHIFT;

	// Configuration registers
	logic [CFG_WIDTH-1:0] low_thr_q, bal_thr_q, high_thr_q, budget_q, window_q;

	// Item registers
	opcode_t               op_q;
	logic [TIME_WIDTH-1:0] start_q, end_q;
	logic [TIER_WIDTH-1:0] tier_q;

	// Governor state
	logic                    started_q;
	logic [TIME_WIDTH-1:0]   sample_start_q;
	logic [COUNT_WIDTH-1:0]  count_q;
	logic [SMOOTH_WIDTH-1:0] smoothed_q;
	logic [RATE_WIDTH-1:0]   rate_q;
	logic [FRAME_WIDTH-1:0]  frame_time_q;
	logic [TIER_WIDTH-1:0]   suggested_q, active_q;
	logic                    lock_q;

	// Working registers
	logic [TIME_WIDTH-1:0]   elapsed_q;
	logic                    neg_q;
	logic [MUL_WIDTH-1:0]    mag_q;
	logic [RECIP_WIDTH-1:0]  recip_q;
	logic [DVD_WIDTH-1:0]    quo_q;
	logic [TIME_WIDTH-1:0]   rem_q;
	logic [CNT_WIDTH-1:0]    cnt_q;

	// Result registers
	logic [TIER_WIDTH-1:0]   res_active_q, res_suggested_q;
	logic                    res_locked_q, res_over_q;
	logic [FRAME_WIDTH-1:0]  res_frame_q;
	logic [SMOOTH_WIDTH-1:0] res_smoothed_q;
	logic [RATE_WIDTH-1:0]   res_rate_q;
	logic [FACTOR_WIDTH-1:0] res_physics_q, res_collision_q;

	// Combinational helpers
	logic [TIME_WIDTH-1:0]       span_c;
	logic [FRAME_WIDTH-1:0]      frame_sat_c;
	logic [SMOOTH_WIDTH-1:0]     frame_q8_c;
	logic [MUL_WIDTH-1:0]        mul_a_c, mul_b_c;
	logic [2*MUL_WIDTH-1:0]      mul_p_c;
	logic [TIME_WIDTH:0]         rem_shift_c;
	logic                        rem_ge_c;
	logic [TIER_WIDTH-1:0]       tier_clamp_c, suggest_c;
	logic [RATE_WIDTH-1:0]       rate_sat_c;
	logic [COUNT_WIDTH-1:0]      count_inc_c;
	logic                        over_c;
	logic [FACTOR_WIDTH-1:0]     physics_c, collision_c;

	// Frame time: wrapping span saturated to 24 bits
	assign span_c      = end_q - start_q;
	assign frame_sat_c = (span_c > TIME_WIDTH'(FRAME_MAX)) ? FRAME_MAX : span_c[FRAME_WIDTH-1:0];
	assign frame_q8_c  = {frame_time_q, {FRAC_BITS{1'b0}}};

	// Shared multiplier: reciprocal of ten for smoothing, rate scale for sampling
	assign mul_a_c = cmd.rate_mul ? MUL_WIDTH'(count_q) : mag_q;
	assign mul_b_c = cmd.rate_mul ? MUL_WIDTH'(RATE_SCALE) : RECIP_TEN;
	assign mul_p_c = mul_a_c * mul_b_c;

	// Restoring divider step, one quotient bit a cycle
	assign rem_shift_c = {rem_q, quo_q[DVD_WIDTH-1]};
	assign rem_ge_c    = rem_shift_c >= {1'b0, elapsed_q};

	assign count_inc_c = (count_q != {COUNT_WIDTH{1'b1}}) ? count_q + COUNT_WIDTH'(1) : count_q;
	assign rate_sat_c  = (|quo_q[DVD_WIDTH-1:RATE_WIDTH]) ? {RATE_WIDTH{1'b1}}
	                                                       : quo_q[RATE_WIDTH-1:0];
	assign tier_clamp_c = (tier_q == TIER_UNUSED) ? TIER_LOW : tier_q;

	// Suggested tier with hysteresis band
	always_comb begin
		if (smoothed_q > {low_thr_q, {FRAC_BITS{1'b0}}}) begin
			suggest_c = TIER_LOW;
		end else if (smoothed_q > {bal_thr_q, {FRAC_BITS{1'b0}}}) begin
			suggest_c = TIER_BALANCED;
		end else if (smoothed_q < {high_thr_q, {FRAC_BITS{1'b0}}}) begin
			suggest_c = TIER_HIGH;
		end else begin
			suggest_c = suggested_q;
		end
	end

	// Budget flag and quarter-step factors
	assign over_c = frame_time_q > budget_q;
	always_comb begin
		if (active_q == TIER_LOW) begin
			physics_c   = FACTOR_QUARTER;
			collision_c = FACTOR_NONE;
		end else if (active_q == TIER_BALANCED || over_c) begin
			physics_c   = FACTOR_HALF;
			collision_c = FACTOR_HALF;
		end else begin
			physics_c   = FACTOR_FULL;
			collision_c = FACTOR_FULL;
		end
	end

	// Status to the controller
	assign status.is_frame   = (op_q == OP_END_FRAME);
	assign status.started    = started_q;
	assign status.window_due = elapsed_q >= TIME_WIDTH'(window_q);
	assign status.div_last   = (cnt_q == CNT_WIDTH'(1));

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_thr_q  <= LOW_POWER_THR_RST;
			bal_thr_q  <= BALANCED_THR_RST;
			high_thr_q <= HIGH_THR_RST;
			budget_q   <= FRAME_BUDGET_RST;
			window_q   <= WINDOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_LOW_POWER_THR: low_thr_q  <= cfg_data;
				CFG_BALANCED_THR:  bal_thr_q  <= cfg_data;
				CFG_HIGH_THR:      high_thr_q <= cfg_data;
				CFG_FRAME_BUDGET:  budget_q   <= cfg_data;
				CFG_WINDOW:        window_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Capture the item and step the working registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q    <= opcode_t'(opcode);
			start_q <= start_time_us;
			end_q   <= end_time_us;
			tier_q  <= tier_value;
		end
		if (cmd.span) begin
			elapsed_q <= end_q - sample_start_q;
		end
		if (cmd.diff) begin
			neg_q <= smoothed_q > frame_q8_c;
			mag_q <= (smoothed_q > frame_q8_c) ? smoothed_q - frame_q8_c
			                                   : frame_q8_c - smoothed_q;
		end
		if (cmd.scale) begin
			recip_q <= mul_p_c[2*MUL_WIDTH-1:RECIP_SHIFT];
		end
		if (cmd.rate_mul) begin
			quo_q <= mul_p_c[DVD_WIDTH-1:0];
			rem_q <= '0;
			cnt_q <= CNT_WIDTH'(DVD_WIDTH);
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[DVD_WIDTH-2:0], rem_ge_c};
			rem_q <= rem_ge_c ? rem_shift_c[TIME_WIDTH-1:0] - elapsed_q
			                  : rem_shift_c[TIME_WIDTH-1:0];
			cnt_q <= cnt_q - CNT_WIDTH'(1);
		end
	end

	// Governor state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q      <= 1'b0;
			sample_start_q <= '0;
			count_q        <= '0;
			smoothed_q     <= '0;
			rate_q         <= RATE_SEED;
			frame_time_q   <= '0;
			suggested_q    <= TIER_HIGH;
			active_q       <= TIER_HIGH;
			lock_q         <= 1'b0;
		end else begin
			if (cmd.span) begin
				frame_time_q <= frame_sat_c;
			end
			// Apply the averaging step; seed the window on the first frame only
			if (cmd.smooth) begin
				smoothed_q <= neg_q ? smoothed_q - SMOOTH_WIDTH'(recip_q)
				                    : smoothed_q + SMOOTH_WIDTH'(recip_q);
				if (!started_q) begin
					started_q      <= 1'b1;
					count_q        <= COUNT_WIDTH'(1);
					sample_start_q <= end_q;
					rate_q         <= RATE_SEED;
				end else begin
					count_q <= count_inc_c;
				end
			end
			// Close the window: store the rate and re-pick the tier
			if (cmd.sample) begin
				rate_q         <= rate_sat_c;
				count_q        <= '0;
				sample_start_q <= end_q;
				suggested_q    <= suggest_c;
				if (!lock_q) begin
					active_q <= suggest_c;
				end
			end
			if (cmd.tier) begin
				case (op_q)
					OP_SET_TIER: begin
						active_q    <= tier_clamp_c;
						suggested_q <= tier_clamp_c;
					end
					OP_SET_PLATFORM: begin
						lock_q   <= 1'b1;
						active_q <= tier_clamp_c;
					end
					OP_CLEAR_LOCK: begin
						lock_q   <= 1'b0;
						active_q <= suggested_q;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			res_active_q    <= active_q;
			res_suggested_q <= suggested_q;
			res_locked_q    <= lock_q;
			res_frame_q     <= frame_time_q;
			res_smoothed_q  <= smoothed_q;
			res_rate_q      <= rate_q;
			res_over_q      <= over_c;
			res_physics_q   <= physics_c;
			res_collision_q <= collision_c;
		end
	end

	assign active_tier        = res_active_q;
	assign suggested_tier     = res_suggested_q;
	assign platform_locked    = res_locked_q;
	assign last_frame_us      = res_frame_q;
	assign smoothed_frame_q8  = res_smoothed_q;
	assign fps_x16            = res_rate_q;
	assign budget_exceeded    = res_over_q;
	assign physics_factor_q   = res_physics_q;
	assign collision_factor_q = res_collision_q;

endmodule

// ===== sv/frame_rate_tier_governor_unit.sv =====
// Tier opcodes go from span straight to done; an end frame runs span, diff, scale and smooth,
// plus rate multiply, the bit-serial frames-per-second divider and sample when a window closes.
// Throughput: one item at a time; the next is accepted the cycle after the result is loaded.
// The result register lets a new item start while the previous result awaits transfer.
// Reset: asynchronous, active low; config returns to defaults, rate to 60 fps, tiers to high.
module frame_rate_tier_governor_unit import frtg_pkg::*; #(
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
	parameter int TIME_WIDTH  = DEF_TIME_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_WIDTH-1:0]       cfg_data,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [1:0]                 opcode,
	input  logic [TIME_WIDTH-1:0]      start_time_us,
	input  logic [TIME_WIDTH-1:0]      end_time_us,
	input  logic [TIER_WIDTH-1:0]      tier_value,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [TIER_WIDTH-1:0]      active_tier,
	output logic [TIER_WIDTH-1:0]      suggested_tier,
	output logic                       platform_locked,
	output logic [FRAME_WIDTH-1:0]     last_frame_us,
	output logic [SMOOTH_WIDTH-1:0]    smoothed_frame_q8,
	output logic [RATE_WIDTH-1:0]      fps_x16,
	output logic                       budget_exceeded,
	output logic [FACTOR_WIDTH-1:0]    physics_factor_q,
	output logic [FACTOR_WIDTH-1:0]    collision_factor_q
);

	cmd_t    cmd;
	status_t status;

	// Controller
	frtg_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// Datapath
	frtg_dpath #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_dpath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.opcode             (opcode),
		.start_time_us      (start_time_us),
		.end_time_us        (end_time_us),
		.tier_value         (tier_value),
		.cmd                (cmd),
		.status             (status),
		.active_tier        (active_tier),
		.suggested_tier     (suggested_tier),
		.platform_locked    (platform_locked),
		.last_frame_us      (last_frame_us),
		.smoothed_frame_q8  (smoothed_frame_q8),
		.fps_x16            (fps_x16),
		.budget_exceeded    (budget_exceeded),
		.physics_factor_q   (physics_factor_q),
		.collision_factor_q (collision_factor_q)
	);

	// An accepted transfer makes the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input not stalled after an accepted transfer");

	// A new result appears only after the controller loads it
	a_result_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(cmd.load_result))
		else $error("result valid rose without a load");

	// Low power tier always runs quarter-step physics with no collision checks
	a_low_power_factors: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && active_tier == TIER_LOW |->
			physics_factor_q == FACTOR_QUARTER && collision_factor_q == FACTOR_NONE)
		else $error("low power tier with wrong factors");

	// Divider steps never overlap an item load
	a_div_isolated: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !cmd.load_item && !cmd.load_result && item_stall)
		else $error("divider step outside a busy frame");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the frame rate tier governor: table-driven directed items, random frames and tier commands.
`timescale 1ns / 100ps

module tb_top;
	import frtg_pkg::*;

	// One result as seen on the output ports
	typedef struct packed {
		logic [TIER_WIDTH-1:0]   active;
		logic [TIER_WIDTH-1:0]   suggested;
		logic                    locked;
		logic [FRAME_WIDTH-1:0]  frame;
		logic [SMOOTH_WIDTH-1:0] smoothed;
		logic [RATE_WIDTH-1:0]   fps;
		logic                    over;
		logic [FACTOR_WIDTH-1:0] physics;
		logic [FACTOR_WIDTH-1:0] collision;
	} gov_result_t;

	// One row of the directed table; want is used only where typed is set
	typedef struct {
		opcode_t         op;
		logic [31:0]     t0;
		logic [31:0]     t1;
		logic [1:0]      tier;
		bit              typed;
		gov_result_t     want;
	} dir_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_WIDTH-1:0]       cfg_data = '0;
	logic                       item_valid = 1'b0;
	logic                       item_stall;
	logic [1:0]                 opcode = '0;
	logic [31:0]                start_time_us = '0;
	logic [31:0]                end_time_us = '0;
	logic [TIER_WIDTH-1:0]      tier_value = '0;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	logic [TIER_WIDTH-1:0]      active_tier;
	logic [TIER_WIDTH-1:0]      suggested_tier;
	logic                       platform_locked;
	logic [FRAME_WIDTH-1:0]     last_frame_us;
	logic [SMOOTH_WIDTH-1:0]    smoothed_frame_q8;
	logic [RATE_WIDTH-1:0]      fps_x16;
	logic                       budget_exceeded;
	logic [FACTOR_WIDTH-1:0]    physics_factor_q;
	logic [FACTOR_WIDTH-1:0]    collision_factor_q;

	frame_rate_tier_governor_unit DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.item_valid         (item_valid),
		.item_stall         (item_stall),
		.opcode             (opcode),
		.start_time_us      (start_time_us),
		.end_time_us        (end_time_us),
		.tier_value         (tier_value),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.active_tier        (active_tier),
		.suggested_tier     (suggested_tier),
		.platform_locked    (platform_locked),
		.last_frame_us      (last_frame_us),
		.smoothed_frame_q8  (smoothed_frame_q8),
		.fps_x16            (fps_x16),
		.budget_exceeded    (budget_exceeded),
		.physics_factor_q   (physics_factor_q),
		.collision_factor_q (collision_factor_q)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor copy of the configuration
	logic [CFG_WIDTH-1:0] thr_low_power = LOW_POWER_THR_RST;
	logic [CFG_WIDTH-1:0] thr_balanced  = BALANCED_THR_RST;
	logic [CFG_WIDTH-1:0] thr_high      = HIGH_THR_RST;
	logic [CFG_WIDTH-1:0] budget_us     = FRAME_BUDGET_RST;
	logic [CFG_WIDTH-1:0] win_us        = WINDOW_RST;

	// Predictor copy of the governor state
	logic                    seen_first       = 1'b0;
	logic [31:0]             window_base_us   = '0;
	logic [15:0]             frames_in_window = '0;
	logic [SMOOTH_WIDTH-1:0] avg_q8           = '0;
	logic [RATE_WIDTH-1:0]   fps_q4           = RATE_SEED;
	logic [FRAME_WIDTH-1:0]  frame_us         = '0;
	logic [TIER_WIDTH-1:0]   tier_suggest     = TIER_HIGH;
	logic [TIER_WIDTH-1:0]   tier_active      = TIER_HIGH;
	logic                    locked           = 1'b0;

	gov_result_t pending_results[$];
	dir_row_t    dir_rows [19];

	int          idle_pct = 0;
	bit          idle_allowed = 1'b1;
	int          stall_run = 0;
	int          mean_us = 16000;
	logic [31:0] wall_us = 32'd2000000;
	int unsigned error_count = 0;
	int unsigned items_sent = 0;
	int unsigned frames_sent = 0;
	int unsigned results_seen = 0;
	int unsigned rate_samples = 0;
	int unsigned sat_windows = 0;
	int unsigned settings_used = 0;

	task automatic report(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	// Advance the governor state by one item and work out the result it shows
	task automatic predict_governor(input opcode_t op, input logic [31:0] t0,
			input logic [31:0] t1, input logic [1:0] tier_in, output gov_result_t r);
		logic [1:0]        tier;
		logic [31:0]       span;
		logic [31:0]       elapsed;
		longint            step;
		longint unsigned   rate;
		logic              over;
		tier = (tier_in == TIER_UNUSED) ? TIER_LOW : tier_in;
		case (op)
		OP_END_FRAME: begin
			frames_sent++;
			span = t1 - t0;
			frame_us = (span > {8'h00, FRAME_MAX}) ? FRAME_MAX : span[FRAME_WIDTH-1:0];
			step = (longint'({frame_us, 8'h00}) - longint'(avg_q8)) / 10;
			avg_q8 = SMOOTH_WIDTH'(longint'(avg_q8) + step);
			if (frames_in_window != 16'hFFFF)
				frames_in_window++;
			if (!seen_first) begin
				// Seed the first window only
				seen_first = 1'b1;
				frames_in_window = 16'd1;
				window_base_us = t1;
				fps_q4 = RATE_SEED;
			end else begin
				elapsed = t1 - window_base_us;
				if (elapsed >= {8'h00, win_us}) begin
					rate_samples++;
					if (frames_in_window == 16'hFFFF)
						sat_windows++;
					if (elapsed == 0) begin
						fps_q4 = 16'hFFFF;
					end else begin
						rate = (64'(frames_in_window) * 64'd16000000) / 64'(elapsed);
						fps_q4 = (rate > 64'd65535) ? 16'hFFFF : rate[15:0];
					end
					frames_in_window = '0;
					window_base_us = t1;
					// Pick a tier with a hysteresis band between high and balanced
					if (avg_q8 > {thr_low_power, 8'h00})
						tier_suggest = TIER_LOW;
					else if (avg_q8 > {thr_balanced, 8'h00})
						tier_suggest = TIER_BALANCED;
					else if (avg_q8 < {thr_high, 8'h00})
						tier_suggest = TIER_HIGH;
					if (!locked)
						tier_active = tier_suggest;
				end
			end
		end
		OP_SET_TIER: begin
			tier_active = tier;
			tier_suggest = tier;
		end
		OP_SET_PLATFORM: begin
			locked = 1'b1;
			tier_active = tier;
		end
		default: begin
			locked = 1'b0;
			tier_active = tier_suggest;
		end
		endcase
		over = frame_us > budget_us;
		r.active = tier_active;
		r.suggested = tier_suggest;
		r.locked = locked;
		r.frame = frame_us;
		r.smoothed = avg_q8;
		r.fps = fps_q4;
		r.over = over;
		if (tier_active == TIER_LOW) begin
			r.physics = FACTOR_QUARTER;
			r.collision = FACTOR_NONE;
		end else if (tier_active == TIER_BALANCED || over) begin
			r.physics = FACTOR_HALF;
			r.collision = FACTOR_HALF;
		end else begin
			r.physics = FACTOR_FULL;
			r.collision = FACTOR_FULL;
		end
	endtask

	// Present one item, hold it until the transfer, then queue its expected result
	task automatic send_item(input opcode_t op, input logic [31:0] t0, input logic [31:0] t1,
			input logic [1:0] tier, input bit typed, input gov_result_t typed_want);
		gov_result_t want;
		item_valid <= 1'b1;
		opcode <= op;
		start_time_us <= t0;
		end_time_us <= t1;
		tier_value <= tier;
		do @(posedge clk); while (item_stall);
		predict_governor(op, t0, t1, tier, want);
		pending_results.push_back(typed ? typed_want : want);
		items_sent++;
	endtask

	// Drop valid for a short burst now and then
	task automatic sender_gap();
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// Hold the sender until every expected result has come back
	task automatic drain(input int tail);
		item_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_WIDTH-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
		CFG_LOW_POWER_THR: thr_low_power = val;
		CFG_BALANCED_THR:  thr_balanced = val;
		CFG_HIGH_THR:      thr_high = val;
		CFG_FRAME_BUDGET:  budget_us = val;
		default:           win_us = val;
		endcase
	endtask

	task automatic apply_setting(input logic [CFG_WIDTH-1:0] lo, input logic [CFG_WIDTH-1:0] bal,
			input logic [CFG_WIDTH-1:0] hi, input logic [CFG_WIDTH-1:0] bud,
			input logic [CFG_WIDTH-1:0] win);
		write_reg(CFG_LOW_POWER_THR, lo);
		write_reg(CFG_BALANCED_THR, bal);
		write_reg(CFG_HIGH_THR, hi);
		write_reg(CFG_FRAME_BUDGET, bud);
		write_reg(CFG_WINDOW, win);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Mostly paced frames on a running clock, plus noise frames and tier commands
	task automatic send_random(input int n);
		logic [31:0] t0;
		logic [31:0] t1;
		logic [31:0] dur;
		opcode_t     op;
		int          pick;
		for (int k = 0; k < n; k++) begin
			if (k % 40 == 0) begin
				case ($urandom_range(0, 3))
				0:       mean_us = $urandom_range(1000, 8000);
				1:       mean_us = $urandom_range(14000, 20000);
				2:       mean_us = $urandom_range(30000, 40000);
				default: mean_us = $urandom_range(100, 70000);
				endcase
				case ($urandom_range(0, 2))
				0:       idle_pct = 0;
				1:       idle_pct = 15;
				default: idle_pct = 40;
				endcase
				if (!idle_allowed)
					idle_pct = 0;
			end
			pick = $urandom_range(0, 99);
			t0 = $urandom;
			t1 = $urandom;
			op = OP_END_FRAME;
			if (pick < 72) begin
				dur = mean_us - mean_us / 8 + $urandom_range(0, mean_us / 4);
				if ($urandom_range(0, 19) == 0)
					dur = $urandom;
				t0 = wall_us + $urandom_range(0, 3000);
				t1 = t0 + dur;
				wall_us = t1;
			end else if (pick < 80) begin
				op = OP_END_FRAME;
			end else if (pick < 88) begin
				op = OP_SET_TIER;
			end else if (pick < 95) begin
				op = OP_SET_PLATFORM;
			end else begin
				op = OP_CLEAR_LOCK;
			end
			send_item(op, t0, t1, 2'($urandom), 1'b0, '0);
			sender_gap();
			if ($urandom_range(0, 199) == 0)
				drain(0);
		end
	endtask

	// Check each result transfer and drive the receiver's stall bursts
	always @(posedge clk) begin
		gov_result_t got;
		gov_result_t want;
		if (result_valid === 1'b1 && result_stall === 1'b0) begin
			results_seen++;
			got = '{active_tier, suggested_tier, platform_locked, last_frame_us,
				smoothed_frame_q8, fps_x16, budget_exceeded, physics_factor_q,
				collision_factor_q};
			if (pending_results.size() == 0) begin
				report("result with no item outstanding", 64'(got), 64'd0);
			end else begin
				want = pending_results.pop_front();
				if (got.active != want.active)
					report("active_tier", 64'(got.active), 64'(want.active));
				if (got.suggested != want.suggested)
					report("suggested_tier", 64'(got.suggested), 64'(want.suggested));
				if (got.locked != want.locked)
					report("platform_locked", 64'(got.locked), 64'(want.locked));
				if (got.frame != want.frame)
					report("last_frame_us", 64'(got.frame), 64'(want.frame));
				if (got.smoothed != want.smoothed)
					report("smoothed_frame_q8", 64'(got.smoothed), 64'(want.smoothed));
				if (got.fps != want.fps)
					report("fps_x16", 64'(got.fps), 64'(want.fps));
				if (got.over != want.over)
					report("budget_exceeded", 64'(got.over), 64'(want.over));
				if (got.physics != want.physics)
					report("physics_factor_q", 64'(got.physics), 64'(want.physics));
				if (got.collision != want.collision)
					report("collision_factor_q", 64'(got.collision),
						64'(want.collision));
			end
		end
		if (stall_run > 0) begin
			stall_run--;
			result_stall <= 1'b1;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			stall_run = $urandom_range(0, 2);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// Main sequence
	initial begin
		dir_rows = '{
			'{OP_CLEAR_LOCK, 32'd0, 32'd0, TIER_HIGH, 1'b1,
				'{TIER_HIGH, TIER_HIGH, 1'b0, 24'd0, 32'd0, RATE_SEED, 1'b0,
				FACTOR_FULL, FACTOR_FULL}},
			'{OP_END_FRAME, 32'd0, 32'hFFFF_FFFF, TIER_HIGH, 1'b1,
				'{TIER_HIGH, TIER_HIGH, 1'b0, FRAME_MAX, 32'd429496704, RATE_SEED, 1'b1,
				FACTOR_HALF, FACTOR_HALF}},
			'{OP_SET_PLATFORM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TIER_UNUSED, 1'b1,
				'{TIER_LOW, TIER_HIGH, 1'b1, FRAME_MAX, 32'd429496704, RATE_SEED, 1'b1,
				FACTOR_QUARTER, FACTOR_NONE}},
			'{OP_CLEAR_LOCK, 32'd0, 32'd0, TIER_UNUSED, 1'b1,
				'{TIER_HIGH, TIER_HIGH, 1'b0, FRAME_MAX, 32'd429496704, RATE_SEED, 1'b1,
				FACTOR_HALF, FACTOR_HALF}},
			'{OP_END_FRAME, 32'hFFFF_FFFF, 32'h0000_0000, TIER_HIGH, 1'b0, '0},
			'{OP_END_FRAME, 32'd100, 32'd100, TIER_UNUSED, 1'b0, '0},
			'{OP_END_FRAME, 32'd583330, 32'd600000, TIER_HIGH, 1'b0, '0},
			'{OP_END_FRAME, 32'd600000, 32'd616671, TIER_HIGH, 1'b0, '0},
			'{OP_SET_TIER, 32'd0, 32'd0, TIER_UNUSED, 1'b0, '0},
			'{OP_SET_PLATFORM, 32'd0, 32'd0, TIER_BALANCED, 1'b0, '0},
			'{OP_SET_TIER, 32'hFFFF_FFFF, 32'd0, TIER_HIGH, 1'b0, '0},
			'{OP_END_FRAME, 32'd1200000, 32'd1240000, TIER_HIGH, 1'b0, '0},
			'{OP_CLEAR_LOCK, 32'd0, 32'd0, TIER_HIGH, 1'b0, '0},
			'{OP_SET_PLATFORM, 32'd0, 32'd0, TIER_HIGH, 1'b0, '0},
			'{OP_SET_PLATFORM, 32'd0, 32'd0, TIER_LOW, 1'b0, '0},
			'{OP_CLEAR_LOCK, 32'd0, 32'd0, TIER_LOW, 1'b0, '0},
			'{OP_END_FRAME, 32'hFF00_0000, 32'h00FF_FFFF, TIER_HIGH, 1'b0, '0},
			'{OP_END_FRAME, 32'h1234_5678, 32'h1334_5677, TIER_HIGH, 1'b0, '0},
			'{OP_END_FRAME, 32'h0000_0000, 32'h0100_0000, TIER_HIGH, 1'b0, '0}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table under the reset configuration
		idle_pct = 25;
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].op, dir_rows[i].t0, dir_rows[i].t1, dir_rows[i].tier,
				dir_rows[i].typed, dir_rows[i].want);
			sender_gap();
		end

		send_random(300);

		// Upper extremes: nothing crosses a threshold, windows rarely close
		drain(60);
		apply_setting(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
		send_random(200);

		// Lower extremes: every frame over budget, a sample on every time step
		drain(60);
		apply_setting(24'd0, 24'd0, 24'd0, 24'd0, 24'd1);
		send_random(200);

		// Random thresholds around typical frame times, short windows
		drain(60);
		apply_setting(24'($urandom_range(20000, 60000)), 24'($urandom_range(10000, 30000)),
			24'($urandom_range(5000, 25000)), 24'($urandom_range(0, 40000)),
			24'($urandom_range(1, 200000)));
		send_random(300);

		// Fully random thresholds, bands possibly inverted
		drain(60);
		apply_setting(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
			24'($urandom_range(1, 24'hFF_FFFF)));
		send_random(200);

		// Pile frames into one long window: close a window, hold elapsed at zero, close again
		drain(60);
		apply_setting(LOW_POWER_THR_RST, BALANCED_THR_RST, HIGH_THR_RST, FRAME_BUDGET_RST,
			24'hFF_FFFF);
		idle_pct = 0;
		send_item(OP_END_FRAME, window_base_us + 32'h00FF_F000,
			window_base_us + 32'h00FF_FFFF, TIER_HIGH, 1'b0, '0);
		repeat (60)
			send_item(OP_END_FRAME, $urandom, window_base_us, 2'($urandom), 1'b0, '0);
		send_item(OP_END_FRAME, window_base_us + 32'h00FF_0000,
			window_base_us + 32'h00FF_FFFF, TIER_HIGH, 1'b0, '0);

		// Closing stretch at the reset configuration with no idling on either side
		drain(60);
		apply_setting(LOW_POWER_THR_RST, BALANCED_THR_RST, HIGH_THR_RST, FRAME_BUDGET_RST,
			WINDOW_RST);
		idle_allowed = 1'b0;
		send_random(400);

		drain(60);
		$display("Covered %0d items (%0d frames) under %0d register settings after reset.",
			items_sent, frames_sent, settings_used);
		$display("Checked %0d results; %0d rate samples, %0d with a saturated frame count.",
			results_seen, rate_samples, sat_windows);
		if (error_count == 0)
			$display("[frame_rate_tier_governor_unit] OK");
		else
			$display("[frame_rate_tier_governor_unit] ERROR");
		$finish;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#4_000_000;
		$display("Timed out with %0d results outstanding.", pending_results.size());
		$display("[frame_rate_tier_governor_unit] ERROR");
		$finish;
	end

endmodule

// ===== frame_rate_tier_governor_unit.f =====
sv/frtg_pkg.sv
sv/frtg_ctrl.sv
sv/frtg_dpath.sv
sv/frame_rate_tier_governor_unit.sv
bench/tb_top.sv
